>>> rtl/tpcd_pkg.sv
package tpcd_pkg;

	// input item kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	// event codes
	localparam logic [4:0] EV_NONE      = 5'd0;
	localparam logic [4:0] EV_NOTE      = 5'd1;
	localparam logic [4:0] EV_ENV_TONE  = 5'd2;
	localparam logic [4:0] EV_REST      = 5'd3;
	localparam logic [4:0] EV_BREAK     = 5'd4;
	localparam logic [4:0] EV_SKIP      = 5'd5;
	localparam logic [4:0] EV_SAMPLE    = 5'd6;
	localparam logic [4:0] EV_ORNAMENT  = 5'd7;
	localparam logic [4:0] EV_VOL_ENV   = 5'd8;
	localparam logic [4:0] EV_VOL_NOENV = 5'd9;
	localparam logic [4:0] EV_NOISE     = 5'd10;
	localparam logic [4:0] EV_CONTINUE  = 5'd11;
	localparam logic [4:0] EV_TEMPO     = 5'd12;
	localparam logic [4:0] EV_GLISS     = 5'd13;
	localparam logic [4:0] EV_SLIDE     = 5'd14;
	localparam logic [4:0] EV_ENV_TYPE  = 5'd15;
	localparam logic [4:0] EV_VOL_SLIDE = 5'd16;
	localparam logic [4:0] EV_PAT_END   = 5'd17;
	localparam logic [4:0] EV_TICK      = 5'd18;
	localparam logic [4:0] EV_TEMPO_ERR = 5'd19;
	localparam logic [4:0] EV_OVERFLOW  = 5'd20;

	// argument awaited by a channel
	localparam logic [2:0] PA_NONE       = 3'd0;
	localparam logic [2:0] PA_ENV_TONE   = 3'd1;
	localparam logic [2:0] PA_NOISE      = 3'd2;
	localparam logic [2:0] PA_TEMPO      = 3'd3;
	localparam logic [2:0] PA_GLISS_DOWN = 3'd4;
	localparam logic [2:0] PA_GLISS_UP   = 3'd5;
	localparam logic [2:0] PA_SLIDE      = 3'd6;
	localparam logic [2:0] PA_VOL_SLIDE  = 3'd7;

	// command bytes of the channel stream
	localparam logic [7:0] CMD_NOTE_MAX   = 8'h55;
	localparam logic [7:0] CMD_UNUSED_LO  = 8'h56;
	localparam logic [7:0] CMD_UNUSED_HI  = 8'h5d;
	localparam logic [7:0] CMD_BREAK      = 8'h5e;
	localparam logic [7:0] CMD_REST       = 8'h5f;
	localparam logic [7:0] CMD_SKIP       = 8'h60;
	localparam logic [7:0] CMD_SAMPLE     = 8'ha0;
	localparam logic [7:0] CMD_ORNAMENT   = 8'hc0;
	localparam logic [7:0] CMD_VOL_ENV    = 8'he0;
	localparam logic [7:0] CMD_VOL_MAX    = 8'hef;
	localparam logic [7:0] CMD_NOISE      = 8'hf0;
	localparam logic [7:0] CMD_CONT_FIRST = 8'hf1;
	localparam logic [7:0] CMD_CONT_LAST  = 8'hf3;
	localparam logic [7:0] CMD_TEMPO      = 8'hf4;
	localparam logic [7:0] CMD_GLISS_DOWN = 8'hf5;
	localparam logic [7:0] CMD_GLISS_UP   = 8'hf6;
	localparam logic [7:0] CMD_CONT_SLIDE = 8'hf7;
	localparam logic [7:0] CMD_ENV_TYPE   = 8'hf8;
	localparam logic [7:0] ENV_TYPE_MASK  = 8'hf9;
	localparam logic [7:0] CMD_SLIDE      = 8'hf9;
	localparam logic [7:0] CMD_VOL_SLIDE  = 8'hfb;
	localparam logic [7:0] CMD_UNUSED_FD  = 8'hfd;
	localparam logic [7:0] CMD_PAT_END    = 8'hff;

	// tempo limits
	localparam logic [7:0] TEMPO_MIN = 8'd3;
	localparam logic [7:0] TEMPO_MAX = 8'd50;

	// per-channel entry kept in the channel memory
	typedef struct packed {
		logic [2:0] pend;
		logic       env_on;
		logic [5:0] period;
	} chan_ent_t;

endpackage

>>> rtl/tracker_pattern_command_decoder.sv
// Pattern command decoder for a three-channel tracker byte stream.
//
// Input channel (in_valid / in_stall): one beat carries kind, chan and
// data_byte. A data byte is decoded into one event for its channel, a row
// tick steps the skip counters and row number, a pattern start clears all.
// Output channel (out_valid / out_stall): exactly one result beat per input
// beat, in order.
//
// Results pass the decode stage register and then the result register, at
// one beat per cycle while the receiver does not stall. The per-channel
// command state sits in a small memory read at accept time into a read
// register; decode modifies and writes the entry back, and a write to the
// entry being read in the same cycle is forwarded into the read register.
//
// Reset clears the pipeline, the row number, the skip counters and the
// entry valid bits, so every channel reads as cleared state. When the
// receiver stalls, the result register holds its beat; one more beat may
// sit in the decode stage, after which in_stall is raised.
module tracker_pattern_command_decoder
	import tpcd_pkg::*;
#(
	parameter int MAX_ROWS     = 64,
	parameter int NUM_CHANNELS = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [1:0]         chan,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         event_res,
	output logic signed [12:0] value,
	output logic signed [1:0]  slide_delta,
	output logic               row_done,
	output logic               cont_sample,
	output logic               cont_ornament,
	output logic [2:0]         feed_mask,
	output logic [6:0]         row_index
);

	localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int RW = $clog2(MAX_ROWS + 1);

	// input side channel address
	logic [3:0]    chan_ext;
	logic          chan_ok;
	logic [CW-1:0] addr_in;

	assign chan_ext = {2'b00, chan};
	assign chan_ok  = chan_ext < 4'(NUM_CHANNELS);
	assign addr_in  = chan_ok ? chan_ext[CW-1:0] : '0;

	// pipeline control
	logic s1_vld_s1;
	logic out_vld_q;
	logic adv;
	logic fire;
	logic accept;

	assign adv      = !out_vld_q || !out_stall;
	assign fire     = s1_vld_s1 && adv;
	assign in_stall = s1_vld_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	// decode stage payload
	logic [1:0]    kind_s1;
	logic [7:0]    byte_s1;
	logic          chan_ok_s1;
	logic [CW-1:0] addr_s1;
	chan_ent_t     rd_s1;
	logic          rd_vld_s1;

	// state kept in flops: touched for every channel at once on a tick or a pattern start
	logic [5:0]              skip_cnt_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] row_start_q;
	logic [NUM_CHANNELS-1:0] ent_vld_q;
	logic [RW-1:0]           cur_row_q;

	// channel memory
	chan_ent_t ent_mem [NUM_CHANNELS];

	// decode results
	chan_ent_t               ent;
	chan_ent_t               ent_nxt;
	logic                    we;
	logic                    clr;
	logic                    tick_ok;
	logic [4:0]              ev;
	logic signed [12:0]      val;
	logic signed [1:0]       sd;
	logic                    done;
	logic                    cs;
	logic                    co;
	logic [NUM_CHANNELS-1:0] feed;
	logic [RW-1:0]           row;
	logic [RW-1:0]           row_prog;
	logic                    first;
	logic [7:0]              skip_val;

	// decode stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_s1 <= 1'b0;
		end else if (accept) begin
			s1_vld_s1 <= 1'b1;
		end else if (fire) begin
			s1_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1    <= kind;
			byte_s1    <= data_byte;
			chan_ok_s1 <= chan_ok;
			addr_s1    <= addr_in;
		end
	end

	// memory write and registered read with forwarding of a same-cycle write
	always_ff @(posedge clk) begin
		if (fire && we) begin
			ent_mem[addr_s1] <= ent_nxt;
		end
		if (accept) begin
			if (fire && clr) begin
				rd_vld_s1 <= 1'b0;
				rd_s1     <= ent_mem[addr_in];
			end else if (fire && we && (addr_s1 == addr_in)) begin
				rd_vld_s1 <= 1'b1;
				rd_s1     <= ent_nxt;
			end else begin
				rd_vld_s1 <= ent_vld_q[addr_in];
				rd_s1     <= ent_mem[addr_in];
			end
		end
	end

	// byte decode
	always_comb begin
		ent      = rd_vld_s1 ? rd_s1 : '0;
		ent_nxt  = ent;
		we       = 1'b0;
		clr      = 1'b0;
		tick_ok  = 1'b0;
		ev       = EV_NONE;
		val      = '0;
		sd       = '0;
		done     = 1'b0;
		cs       = 1'b0;
		co       = 1'b0;
		feed     = '0;
		first    = 1'b0;
		row_prog = (cur_row_q == '0) ? '0 : cur_row_q - RW'(1);
		row      = row_prog;
		skip_val = byte_s1 - CMD_SKIP;
		case (kind_s1)
			KIND_START: begin
				clr = 1'b1;
				row = '0;
			end
			KIND_TICK: begin
				if (cur_row_q >= RW'(MAX_ROWS)) begin
					ev = EV_OVERFLOW;
				end else begin
					ev      = EV_TICK;
					tick_ok = 1'b1;
					row     = cur_row_q;
					for (int c = 0; c < NUM_CHANNELS; c++) begin
						feed[c] = (skip_cnt_q[c] == 6'd0);
					end
				end
			end
			KIND_DATA: begin
				if (chan_ok_s1) begin
					we    = 1'b1;
					first = row_start_q[addr_s1];
					if (ent.pend != PA_NONE) begin
						// argument byte of a pending command
						ent_nxt.pend = PA_NONE;
						case (ent.pend)
							PA_ENV_TONE: begin
								ev   = EV_ENV_TONE;
								val  = {5'b0, byte_s1};
								done = 1'b1;
							end
							PA_NOISE: begin
								ev  = EV_NOISE;
								val = {5'b0, byte_s1};
							end
							PA_TEMPO: begin
								ev  = (byte_s1 >= TEMPO_MIN && byte_s1 <= TEMPO_MAX) ?
									EV_TEMPO : EV_TEMPO_ERR;
								val = {5'b0, byte_s1};
							end
							PA_GLISS_DOWN: begin
								ev  = EV_GLISS;
								val = 13'sd0 - $signed({1'b0, byte_s1, 4'h0});
							end
							PA_GLISS_UP: begin
								ev  = EV_GLISS;
								val = $signed({1'b0, byte_s1, 4'h0});
							end
							PA_SLIDE: begin
								ev  = EV_SLIDE;
								val = {{5{byte_s1[7]}}, byte_s1};
							end
							PA_VOL_SLIDE: begin
								ev  = EV_VOL_SLIDE;
								val = {8'b0, byte_s1[4:0]};
								sd  = byte_s1[5] ? -2'sd1 : 2'sd1;
							end
							default: begin
								ev = EV_NONE;
							end
						endcase
					end else if (addr_s1 == '0 && first && byte_s1 == CMD_PAT_END) begin
						// pattern end at the start of the first channel's row
						ev  = EV_PAT_END;
						val = 13'((row_prog == '0) ? RW'(1) : row_prog);
					end else if (byte_s1 <= CMD_NOTE_MAX) begin
						ev  = EV_NOTE;
						val = {5'b0, byte_s1};
						if (ent.env_on) begin
							ent_nxt.pend = PA_ENV_TONE;
						end else begin
							done = 1'b1;
						end
					end else if (byte_s1 <= CMD_UNUSED_HI) begin
						done = 1'b1;
					end else if (byte_s1 == CMD_BREAK) begin
						ev   = EV_BREAK;
						done = 1'b1;
					end else if (byte_s1 == CMD_REST) begin
						ev   = EV_REST;
						done = 1'b1;
					end else if (byte_s1 < CMD_SAMPLE) begin
						ev             = EV_SKIP;
						val            = {5'b0, skip_val};
						ent_nxt.period = skip_val[5:0];
					end else if (byte_s1 < CMD_ORNAMENT) begin
						ev  = EV_SAMPLE;
						val = {8'b0, byte_s1[4:0]};
					end else if (byte_s1 < CMD_VOL_ENV) begin
						ev  = EV_ORNAMENT;
						val = {8'b0, byte_s1[4:0]};
					end else if (byte_s1 == CMD_VOL_ENV) begin
						ev             = EV_VOL_ENV;
						val            = 13'sd15;
						ent_nxt.env_on = 1'b1;
					end else if (byte_s1 <= CMD_VOL_MAX) begin
						ev             = EV_VOL_NOENV;
						val            = {9'b0, byte_s1[3:0]};
						ent_nxt.env_on = 1'b0;
					end else if (byte_s1 == CMD_NOISE) begin
						ent_nxt.pend = PA_NOISE;
					end else if (byte_s1 <= CMD_CONT_LAST) begin
						ev = EV_CONTINUE;
						cs = byte_s1[0];
						co = byte_s1[1];
					end else if (byte_s1 == CMD_TEMPO) begin
						ent_nxt.pend = PA_TEMPO;
					end else if (byte_s1 == CMD_GLISS_DOWN) begin
						ent_nxt.pend = PA_GLISS_DOWN;
					end else if (byte_s1 == CMD_GLISS_UP) begin
						ent_nxt.pend = PA_GLISS_UP;
					end else if (byte_s1 == CMD_CONT_SLIDE) begin
						ev           = EV_CONTINUE;
						cs           = 1'b1;
						ent_nxt.pend = PA_SLIDE;
					end else if (byte_s1 == CMD_SLIDE) begin
						ent_nxt.pend = PA_SLIDE;
					end else if ((byte_s1 & ENV_TYPE_MASK) == CMD_ENV_TYPE) begin
						ev  = EV_ENV_TYPE;
						val = {9'b0, byte_s1[3:0]};
					end else if (byte_s1 == CMD_VOL_SLIDE) begin
						ent_nxt.pend = PA_VOL_SLIDE;
					end
				end
			end
			default: begin
				ev = EV_NONE;
			end
		endcase
	end

	// counters, row-start flags, row number and entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q   <= '0;
			row_start_q <= '0;
			ent_vld_q   <= '0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				skip_cnt_q[c] <= 6'd0;
			end
		end else if (fire) begin
			if (clr) begin
				cur_row_q   <= '0;
				row_start_q <= '0;
				ent_vld_q   <= '0;
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					skip_cnt_q[c] <= 6'd0;
				end
			end else if (tick_ok) begin
				cur_row_q <= cur_row_q + RW'(1);
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					if (skip_cnt_q[c] != 6'd0) begin
						skip_cnt_q[c] <= skip_cnt_q[c] - 6'd1;
					end else begin
						row_start_q[c] <= 1'b1;
					end
				end
			end else if (we) begin
				ent_vld_q[addr_s1]   <= 1'b1;
				row_start_q[addr_s1] <= 1'b0;
				if (done) begin
					skip_cnt_q[addr_s1] <= ent_nxt.period;
				end
			end
		end
	end

	// result register
	logic [4:0]         ev_q;
	logic signed [12:0] val_q;
	logic signed [1:0]  sd_q;
	logic               done_q;
	logic               cs_q;
	logic               co_q;
	logic [2:0]         feed_q;
	logic [6:0]         row_q;
	logic [7:0]         feed_ext;

	assign feed_ext = 8'(feed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= s1_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ev_q   <= ev;
			val_q  <= val;
			sd_q   <= sd;
			done_q <= done;
			cs_q   <= cs;
			co_q   <= co;
			feed_q <= feed_ext[2:0];
			row_q  <= 7'(row);
		end
	end

	assign out_valid     = out_vld_q;
	assign event_res     = ev_q;
	assign value         = val_q;
	assign slide_delta   = sd_q;
	assign row_done      = done_q;
	assign cont_sample   = cs_q;
	assign cont_ornament = co_q;
	assign feed_mask     = feed_q;
	assign row_index     = row_q;

endmodule
